[sv/limit_order_book_matcher_assert.svh]
// Assertion macros for the order book matcher.
`ifndef LIMIT_ORDER_BOOK_MATCHER_ASSERT_SVH
`define LIMIT_ORDER_BOOK_MATCHER_ASSERT_SVH

// Implication checked at every clock edge outside reset.
`define LOBM_CHECK(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Condition that must never be seen outside reset.
`define LOBM_NEVER(label, cond, msg) \
	`LOBM_CHECK(label, 1'b1, !(cond), msg)

`endif

[sv/lobm_pkg.sv]
package lobm_pkg;

	// opcodes
	localparam logic [1:0] OP_ADD    = 2'd0;
	localparam logic [1:0] OP_CANCEL = 2'd1;
	localparam logic [1:0] OP_MARKET = 2'd2;

	// result status codes
	localparam logic [2:0] ST_ADDED   = 3'd0;
	localparam logic [2:0] ST_DUP     = 3'd1;
	localparam logic [2:0] ST_CANCEL  = 3'd2;
	localparam logic [2:0] ST_UNKNOWN = 3'd3;
	localparam logic [2:0] ST_FILL    = 3'd4;
	localparam logic [2:0] ST_NOLIQ   = 3'd5;

	// ticks per occupancy bitmap word
	localparam int OCC_BITS = 32;

endpackage

[sv/limit_order_book_matcher.sv]
// Limit order book matcher, price-time priority. An item is taken when start is high
// and busy is low; every result appears for one cycle with strobe high and must be
// taken then, since the receiver cannot stall the block. After reset the block runs a
// clearing pass over the order slots with busy high. An add or a cancel gives a single
// result, also a cancel of an id that is not resting. A market order makes at most
// MAX_FILLS fills, each one paid for by a chain of single-port reads: occupancy word,
// level head, order slot. Each fill is reported one fill late, so the last result of
// a market order carries the dropped remainder in unfilled_qty; with no fill at all
// one "no liquidity" result is given. Orders live in slot memories indexed by order
// id, each price level holds a linked FIFO, and best-price search goes through an
// occupancy bitmap with a per-word summary kept in flops.
`include "limit_order_book_matcher_assert.svh"

module limit_order_book_matcher #(
	parameter int PRICE_LEVELS = 256,
	parameter int MAX_ORDERS   = 1024,
	parameter int MAX_FILLS    = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  opcode,
	input  logic        side,
	input  logic [7:0]  price_tick,
	input  logic [31:0] quantity,
	input  logic [9:0]  order_id,
	output logic        strobe,
	output logic [2:0]  status,
	output logic [9:0]  resting_id,
	output logic [31:0] exec_qty,
	output logic [7:0]  fill_price,
	output logic [31:0] unfilled_qty,
	output logic        last
);

	localparam int SW  = $clog2(MAX_ORDERS);      // slot index bits
	localparam int PW  = $clog2(PRICE_LEVELS);    // tick bits
	localparam int LW  = PW + 1;                  // level index {side, tick}
	localparam int WB  = (PW > 5) ? PW - 5 : 1;   // bitmap word index bits per side
	localparam int NWD = 2 ** WB;                 // bitmap words per side
	localparam int OAW = WB + 1;                  // bitmap address {side, word}
	localparam int IW  = PW + 34;                 // slot info {valid, side, tick, size}
	localparam int OB  = lobm_pkg::OCC_BITS;

	// sequencer states
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_A0   = 4'd1;   // add: read slot, tail, bitmap
	localparam logic [3:0] S_A1   = 4'd2;   // add: link in and reply
	localparam logic [3:0] S_C0   = 4'd3;   // cancel: read slot
	localparam logic [3:0] S_C1   = 4'd4;   // cancel: check, read links
	localparam logic [3:0] S_C2   = 4'd5;   // cancel: capture links
	localparam logic [3:0] S_C3   = 4'd6;   // cancel: unlink and reply
	localparam logic [3:0] S_MS   = 4'd7;   // market: pick best word or finish
	localparam logic [3:0] S_M1   = 4'd8;   // market: pick tick, read head/tail
	localparam logic [3:0] S_M2   = 4'd9;   // market: read resting slot
	localparam logic [3:0] S_M3   = 4'd10;  // market: capture slot
	localparam logic [3:0] S_M4   = 4'd11;  // market: fill, maybe unlink

	function automatic logic [WB-1:0] word_of(input logic [PW-1:0] p);
		logic [12:0] pe;
		pe = 13'(p);
		return pe[WB+4:5];
	endfunction

	function automatic logic [4:0] bit_of(input logic [PW-1:0] p);
		logic [12:0] pe;
		pe = 13'(p);
		return pe[4:0];
	endfunction

	// control
	logic [3:0]    state_q;
	logic          clearing_q;
	logic [SW:0]   clr_cnt_q;
	logic [2*NWD-1:0] sum_q;       // bitmap word nonzero, per {side, word}
	logic          pend_q;
	logic [6:0]    nfill_q;
	logic          strobe_q;

	// item and working registers
	logic [1:0]    op_q;
	logic          side_q;
	logic [SW-1:0] id_q;
	logic          idok_q;
	logic [31:0]   qty_q;
	logic [31:0]   rem_q;
	logic [LW-1:0] lv_q;
	logic [WB-1:0] fw_q;
	logic [SW-1:0] s_q;
	logic [SW-1:0] head_q;
	logic [SW-1:0] tail_q;
	logic [SW-1:0] nxt_q;
	logic [SW-1:0] prv_q;
	logic [OB-1:0] occw_q;
	logic [31:0]   sz_q;
	logic [PW-1:0] pr_q;
	logic [SW-1:0] pend_id_q;
	logic [31:0]   pend_qty_q;
	logic [PW-1:0] pend_pr_q;

	// result word
	logic [2:0]    status_q;
	logic [9:0]    rid_q;
	logic [31:0]   fqty_q;
	logic [7:0]    fprice_q;
	logic [31:0]   unf_q;
	logic          last_q;

	// memory ports
	logic          slot_we, head_we, tail_we, next_we, prev_we, occ_we;
	logic [SW-1:0] slot_wa, slot_ra, next_wa, next_ra, prev_wa, prev_ra;
	logic [IW-1:0] slot_wd, slot_rd;
	logic [LW-1:0] head_wa, tail_wa, lev_ra;
	logic [SW-1:0] head_wd, tail_wd, next_wd, prev_wd;
	logic [SW-1:0] head_rd, tail_rd, next_rd, prev_rd;
	logic [OAW-1:0] occ_wa, occ_ra;
	logic [OB-1:0] occ_wd, occ_rd;

	lobm_ram #(.W(IW), .D(MAX_ORDERS)) u_slot (
		.clk, .we(slot_we), .waddr(slot_wa), .wdata(slot_wd), .raddr(slot_ra), .rdata(slot_rd));
	lobm_ram #(.W(SW), .D(MAX_ORDERS)) u_next (
		.clk, .we(next_we), .waddr(next_wa), .wdata(next_wd), .raddr(next_ra), .rdata(next_rd));
	lobm_ram #(.W(SW), .D(MAX_ORDERS)) u_prev (
		.clk, .we(prev_we), .waddr(prev_wa), .wdata(prev_wd), .raddr(prev_ra), .rdata(prev_rd));
	lobm_ram #(.W(SW), .D(2 ** LW)) u_head (
		.clk, .we(head_we), .waddr(head_wa), .wdata(head_wd), .raddr(lev_ra), .rdata(head_rd));
	lobm_ram #(.W(SW), .D(2 ** LW)) u_tail (
		.clk, .we(tail_we), .waddr(tail_wa), .wdata(tail_wd), .raddr(lev_ra), .rdata(tail_rd));
	lobm_ram #(.W(OB), .D(2 ** OAW)) u_occ (
		.clk, .we(occ_we), .waddr(occ_wa), .wdata(occ_wd), .raddr(occ_ra), .rdata(occ_rd));

	// slot read fields
	logic          s_valid, s_side;
	logic [PW-1:0] s_price;
	logic [31:0]   s_size;
	assign s_valid = slot_rd[IW-1];
	assign s_side  = slot_rd[IW-2];
	assign s_price = slot_rd[IW-3 -: PW];
	assign s_size  = slot_rd[31:0];

	// best-price search: summary word, then tick within the word
	logic          opp;
	logic [NWD-1:0] sum_side;
	logic          sp_found, bp_found;
	logic [WB-1:0] sp_idx;
	logic [4:0]    bp_idx;
	logic [LW-1:0] lv_m;
	assign opp      = ~side_q;
	assign sum_side = opp ? sum_q[2*NWD-1:NWD] : sum_q[NWD-1:0];

	lobm_pick #(.N(NWD), .IW(WB)) u_pick_word (
		.vec(sum_side), .lowest(opp), .found(sp_found), .idx(sp_idx));
	lobm_pick #(.N(OB), .IW(5)) u_pick_tick (
		.vec(occ_rd), .lowest(opp), .found(bp_found), .idx(bp_idx));

	assign lv_m = {opp, PW'({fw_q, bp_idx})};

	// bitmap word of the level in lv_q; a word never set reads as empty
	logic [OAW-1:0] lv_oa;
	logic [OB-1:0]  occ_m, lv_mask;
	assign lv_oa   = {lv_q[LW-1], word_of(lv_q[PW-1:0])};
	assign occ_m   = sum_q[lv_oa] ? occ_rd : '0;
	assign lv_mask = OB'(1) << bit_of(lv_q[PW-1:0]);

	// add decisions
	logic add_ok, add_occ;
	assign add_ok  = idok_q && !s_valid;
	assign add_occ = occ_m[bit_of(lv_q[PW-1:0])];

	// fill arithmetic
	logic [31:0] f_qty, new_size;
	assign f_qty    = (sz_q < rem_q) ? sz_q : rem_q;
	assign new_size = sz_q - f_qty;

	// unlink of s_q from level lv_q
	logic unl_en, is_head, is_tail;
	logic [OB-1:0] unl_word;
	assign unl_en   = (state_q == S_C3) || (state_q == S_M4 && new_size == '0);
	assign is_head  = head_q == s_q;
	assign is_tail  = tail_q == s_q;
	assign unl_word = occw_q & ~lv_mask;

	// read addresses
	always_comb begin
		unique case (state_q)
			S_M2:    slot_ra = head_rd;
			default: slot_ra = id_q;
		endcase
		unique case (state_q)
			S_M1:    lev_ra = lv_m;
			S_C1:    lev_ra = {s_side, s_price};
			default: lev_ra = lv_q;
		endcase
		unique case (state_q)
			S_M2:    next_ra = head_rd;
			S_C1:    next_ra = id_q;
			default: next_ra = s_q;
		endcase
		prev_ra = next_ra;
		unique case (state_q)
			S_MS:    occ_ra = {opp, sp_idx};
			S_C1:    occ_ra = {s_side, word_of(s_price)};
			default: occ_ra = lv_oa;
		endcase
	end

	// writes
	always_comb begin
		slot_we = 1'b0; slot_wa = s_q;  slot_wd = '0;
		head_we = 1'b0; head_wa = lv_q; head_wd = id_q;
		tail_we = 1'b0; tail_wa = lv_q; tail_wd = id_q;
		next_we = 1'b0; next_wa = prv_q; next_wd = nxt_q;
		prev_we = 1'b0; prev_wa = nxt_q; prev_wd = prv_q;
		occ_we  = 1'b0; occ_wa  = lv_oa; occ_wd  = unl_word;
		if (clearing_q) begin
			slot_we = 1'b1;
			slot_wa = clr_cnt_q[SW-1:0];
		end else if (state_q == S_A1 && add_ok) begin
			slot_we = 1'b1;
			slot_wa = id_q;
			slot_wd = {1'b1, side_q, lv_q[PW-1:0], qty_q};
			tail_we = 1'b1;
			if (add_occ) begin
				prev_we = 1'b1; prev_wa = id_q;    prev_wd = tail_rd;
				next_we = 1'b1; next_wa = tail_rd; next_wd = id_q;
			end else begin
				head_we = 1'b1;
				occ_we  = 1'b1;
				occ_wd  = occ_m | lv_mask;
			end
		end else if (unl_en) begin
			slot_we = 1'b1;
			priority if (is_head && is_tail) begin
				occ_we = 1'b1;
			end else if (is_head) begin
				head_we = 1'b1; head_wd = nxt_q;
			end else if (is_tail) begin
				tail_we = 1'b1; tail_wd = prv_q;
			end else begin
				next_we = 1'b1;
				prev_we = 1'b1;
			end
		end else if (state_q == S_M4) begin
			// partial fill keeps its place with reduced size
			slot_we = 1'b1;
			slot_wd = {1'b1, ~side_q, pr_q, new_size};
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			clearing_q <= 1'b1;
			clr_cnt_q  <= '0;
			sum_q      <= '0;
			pend_q     <= 1'b0;
			nfill_q    <= '0;
			strobe_q   <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			if (clearing_q) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (clr_cnt_q == (SW+1)'(MAX_ORDERS - 1)) begin
					clearing_q <= 1'b0;
				end
			end
			if (state_q == S_A1 && add_ok && !add_occ) begin
				sum_q[lv_oa] <= 1'b1;
			end
			if (unl_en && is_head && is_tail) begin
				sum_q[lv_oa] <= unl_word != '0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start && !busy) begin
						nfill_q <= '0;
						pend_q  <= 1'b0;
						unique case (opcode)
							lobm_pkg::OP_ADD:    state_q <= S_A0;
							lobm_pkg::OP_CANCEL: state_q <= S_C0;
							lobm_pkg::OP_MARKET: state_q <= S_MS;
							default:             state_q <= S_IDLE;
						endcase
					end
				end
				S_A0: state_q <= S_A1;
				S_A1: begin
					strobe_q <= 1'b1;
					state_q  <= S_IDLE;
				end
				S_C0: state_q <= S_C1;
				S_C1: begin
					if (!idok_q || !s_valid) begin
						strobe_q <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						state_q <= S_C2;
					end
				end
				S_C2: state_q <= S_C3;
				S_C3: begin
					strobe_q <= 1'b1;
					state_q  <= S_IDLE;
				end
				S_MS: begin
					if (rem_q == '0 || nfill_q == 7'(MAX_FILLS) || !sp_found) begin
						strobe_q <= 1'b1;
						pend_q   <= 1'b0;
						state_q  <= S_IDLE;
					end else begin
						state_q <= S_M1;
					end
				end
				S_M1: state_q <= S_M2;
				S_M2: state_q <= S_M3;
				S_M3: state_q <= S_M4;
				S_M4: begin
					strobe_q <= pend_q;
					pend_q   <= 1'b1;
					nfill_q  <= nfill_q + 1'b1;
					state_q  <= S_MS;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				op_q   <= opcode;
				side_q <= side;
				id_q   <= SW'(order_id);
				idok_q <= 17'(order_id) < 17'(MAX_ORDERS);
				qty_q  <= quantity;
				rem_q  <= quantity;
				// tick saturates to the top level
				if (13'(price_tick) >= 13'(PRICE_LEVELS)) begin
					lv_q <= {side, PW'(PRICE_LEVELS - 1)};
				end else begin
					lv_q <= {side, PW'(price_tick)};
				end
			end
			S_A1: begin
				status_q <= add_ok ? lobm_pkg::ST_ADDED : lobm_pkg::ST_DUP;
				rid_q    <= '0;
				fqty_q   <= '0;
				fprice_q <= '0;
				unf_q    <= '0;
				last_q   <= 1'b1;
			end
			S_C1: begin
				lv_q     <= {s_side, s_price};
				s_q      <= id_q;
				status_q <= lobm_pkg::ST_UNKNOWN;
				rid_q    <= '0;
				fqty_q   <= '0;
				fprice_q <= '0;
				unf_q    <= '0;
				last_q   <= 1'b1;
			end
			S_C2: begin
				head_q <= head_rd;
				tail_q <= tail_rd;
				nxt_q  <= next_rd;
				prv_q  <= prev_rd;
				occw_q <= occ_m;
			end
			S_C3: status_q <= lobm_pkg::ST_CANCEL;
			S_MS: begin
				fw_q   <= sp_idx;
				unf_q  <= rem_q;
				last_q <= 1'b1;
				if (pend_q) begin
					status_q <= lobm_pkg::ST_FILL;
					rid_q    <= 10'(17'(pend_id_q));
					fqty_q   <= pend_qty_q;
					fprice_q <= 8'(13'(pend_pr_q));
				end else begin
					status_q <= lobm_pkg::ST_NOLIQ;
					rid_q    <= '0;
					fqty_q   <= '0;
					fprice_q <= '0;
				end
			end
			S_M1: begin
				occw_q <= occ_rd;
				lv_q   <= lv_m;
			end
			S_M2: begin
				head_q <= head_rd;
				tail_q <= tail_rd;
				s_q    <= head_rd;
			end
			S_M3: begin
				sz_q  <= s_size;
				pr_q  <= s_price;
				nxt_q <= next_rd;
				prv_q <= prev_rd;
			end
			S_M4: begin
				status_q   <= lobm_pkg::ST_FILL;
				rid_q      <= 10'(17'(pend_id_q));
				fqty_q     <= pend_qty_q;
				fprice_q   <= 8'(13'(pend_pr_q));
				unf_q      <= '0;
				last_q     <= 1'b0;
				pend_id_q  <= s_q;
				pend_qty_q <= f_qty;
				pend_pr_q  <= pr_q;
				rem_q      <= rem_q - f_qty;
			end
			default: ;
		endcase
	end

	assign busy         = clearing_q || (state_q != S_IDLE);
	assign strobe       = strobe_q;
	assign status       = status_q;
	assign resting_id   = rid_q;
	assign exec_qty     = fqty_q;
	assign fill_price   = fprice_q;
	assign unfilled_qty = unf_q;
	assign last         = last_q;

	// op_q kept for debug visibility of the item in flight
	logic op_is_market;
	assign op_is_market = op_q == lobm_pkg::OP_MARKET;

	`LOBM_CHECK(a_add_reply, $past(start && !busy && opcode == lobm_pkg::OP_ADD, 3), strobe && last, "add gave no reply")
	`LOBM_CHECK(a_only_fill_continues, strobe && !last, status == lobm_pkg::ST_FILL && op_is_market, "non-final result is not a fill")
	`LOBM_NEVER(a_no_result_clearing, strobe && clearing_q, "result during clearing pass")
	`LOBM_CHECK(a_fill_cap, state_q == S_MS, nfill_q <= 7'(MAX_FILLS), "fill count past cap")

endmodule

[sv/lobm_ram.sv]
module lobm_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[sv/lobm_pick.sv]
// Priority pick of the lowest or highest set bit.
module lobm_pick #(
	parameter int N  = 32,
	parameter int IW = 5
) (
	input  logic [N-1:0]  vec,
	input  logic          lowest,
	output logic          found,
	output logic [IW-1:0] idx
);

	always_comb begin
		found = |vec;
		idx   = '0;
		if (lowest) begin
			for (int i = N - 1; i >= 0; i--) begin
				if (vec[i]) begin
					idx = IW'(i);
				end
			end
		end else begin
			for (int i = 0; i < N; i++) begin
				if (vec[i]) begin
					idx = IW'(i);
				end
			end
		end
	end

endmodule

[sim/lobm_checker.sv]
`timescale 1ns / 1ps

module lobm_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [1:0]  opcode,
	input  logic        side,
	input  logic [7:0]  price_tick,
	input  logic [31:0] quantity,
	input  logic [9:0]  order_id,
	input  logic        strobe,
	input  logic [2:0]  status,
	input  logic [9:0]  resting_id,
	input  logic [31:0] exec_qty,
	input  logic [7:0]  fill_price,
	input  logic [31:0] unfilled_qty,
	input  logic        last,
	output int          fail_count,
	output int          pending
);

	localparam int LEVELS = 256;
	localparam int ORDERS = 1024;
	localparam int FILL_CAP = 64;
	localparam int QD = 256;

	typedef struct packed {
		logic [2:0]  status;
		logic [9:0]  resting_id;
		logic [31:0] exec_qty;
		logic [7:0]  fill_price;
		logic [31:0] unfilled_qty;
		logic        last;
	} book_word_t;

	// expected words, circular
	book_word_t exp_q[QD];
	int q_rd = 0;
	int q_wr = 0;
	int q_cnt = 0;

	bit          ord_live[ORDERS];
	bit          ord_side[ORDERS];
	logic [7:0]  ord_price[ORDERS];
	logic [31:0] ord_size[ORDERS];
	logic [9:0]  ord_next[ORDERS];
	logic [9:0]  ord_prev[ORDERS];
	logic [9:0]  lvl_head[2*LEVELS];
	logic [9:0]  lvl_tail[2*LEVELS];
	bit          lvl_busy[2*LEVELS];

	assign pending = q_cnt;

	function automatic book_word_t mk(logic [2:0] st, logic [9:0] rid, logic [31:0] q,
		logic [7:0] p, logic [31:0] u, logic l);
		book_word_t w;
		w.status = st; w.resting_id = rid; w.exec_qty = q;
		w.fill_price = p; w.unfilled_qty = u; w.last = l;
		return w;
	endfunction

	function automatic void add_word(book_word_t w);
		exp_q[q_wr] = w;
		q_wr = (q_wr + 1) % QD;
		q_cnt++;
	endfunction

	function automatic void unlink_order(int s);
		int lv;
		lv = ord_side[s] * LEVELS + ord_price[s];
		if (lvl_head[lv] == s && lvl_tail[lv] == s) lvl_busy[lv] = 0;
		else if (lvl_head[lv] == s) lvl_head[lv] = ord_next[s];
		else if (lvl_tail[lv] == s) lvl_tail[lv] = ord_prev[s];
		else begin
			ord_next[ord_prev[s]] = ord_next[s];
			ord_prev[ord_next[s]] = ord_prev[s];
		end
		ord_live[s] = 0;
	endfunction

	// best level: lowest tick for sells, highest for buys; -1 when side empty
	function automatic int best_tick_level(bit sd);
		for (int i = 0; i < LEVELS; i++) begin
			int lv;
			lv = sd ? (LEVELS + i) : (LEVELS - 1 - i);
			if (lvl_busy[lv]) return lv;
		end
		return -1;
	endfunction

	task automatic predict_book(logic [1:0] op, logic sd, logic [7:0] px,
		logic [31:0] qty, logic [9:0] id);
		int lv, n, s, tl;
		logic [31:0] rem, f;
		case (op)
			lobm_pkg::OP_ADD: begin
				if (ord_live[id]) add_word(mk(lobm_pkg::ST_DUP, '0, '0, '0, '0, 1'b1));
				else begin
					lv = sd * LEVELS + px;
					ord_live[id] = 1; ord_side[id] = sd;
					ord_price[id] = px; ord_size[id] = qty;
					if (lvl_busy[lv]) begin
						ord_prev[id] = lvl_tail[lv];
						ord_next[lvl_tail[lv]] = id;
						lvl_tail[lv] = id;
					end else begin
						lvl_busy[lv] = 1; lvl_head[lv] = id; lvl_tail[lv] = id;
					end
					add_word(mk(lobm_pkg::ST_ADDED, '0, '0, '0, '0, 1'b1));
				end
			end
			lobm_pkg::OP_CANCEL: begin
				if (!ord_live[id])
					add_word(mk(lobm_pkg::ST_UNKNOWN, '0, '0, '0, '0, 1'b1));
				else begin
					unlink_order(id);
					add_word(mk(lobm_pkg::ST_CANCEL, '0, '0, '0, '0, 1'b1));
				end
			end
			lobm_pkg::OP_MARKET: begin
				rem = qty;
				n = 0;
				while (rem > 0 && n < FILL_CAP) begin
					lv = best_tick_level(!sd);
					if (lv < 0) break;
					s = lvl_head[lv];
					f = (ord_size[s] < rem) ? ord_size[s] : rem;
					ord_size[s] -= f;
					rem -= f;
					add_word(mk(lobm_pkg::ST_FILL, 10'(s), f, ord_price[s], '0, 1'b0));
					n++;
					if (ord_size[s] == 0) unlink_order(s);
				end
				if (n == 0) add_word(mk(lobm_pkg::ST_NOLIQ, '0, '0, '0, rem, 1'b1));
				else begin
					// remainder and end mark ride on the final fill
					tl = (q_wr + QD - 1) % QD;
					exp_q[tl].unfilled_qty = rem;
					exp_q[tl].last = 1'b1;
				end
			end
			default: ; // unused opcode: no word
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		book_word_t exp_w;
		int errs;
		if (!arst_n) begin
			fail_count <= 0;
			q_rd = 0; q_wr = 0; q_cnt = 0;
			for (int i = 0; i < ORDERS; i++) ord_live[i] = 0;
			for (int i = 0; i < 2*LEVELS; i++) lvl_busy[i] = 0;
		end else begin
			errs = 0;
			if (strobe) begin
				if (q_cnt == 0) begin
					$error("unexpected result word, status %0d", status);
					errs++;
				end else begin
					exp_w = exp_q[q_rd];
					q_rd = (q_rd + 1) % QD;
					q_cnt--;
					if (status !== exp_w.status) begin
						$error("status exp %0d got %0d", exp_w.status, status);
						errs++;
					end
					if (resting_id !== exp_w.resting_id) begin
						$error("resting_id exp %0d got %0d", exp_w.resting_id, resting_id);
						errs++;
					end
					if (exec_qty !== exp_w.exec_qty) begin
						$error("exec_qty exp %0d got %0d", exp_w.exec_qty, exec_qty);
						errs++;
					end
					if (fill_price !== exp_w.fill_price) begin
						$error("fill_price exp %0d got %0d", exp_w.fill_price, fill_price);
						errs++;
					end
					if (unfilled_qty !== exp_w.unfilled_qty) begin
						$error("unfilled_qty exp %0d got %0d", exp_w.unfilled_qty,
							unfilled_qty);
						errs++;
					end
					if (last !== exp_w.last) begin
						$error("last exp %0d got %0d", exp_w.last, last);
						errs++;
					end
				end
			end
			// predict after the compare so a same-edge word is never matched early
			if (start && !busy)
				predict_book(opcode, side, price_tick, quantity, order_id);
			if (errs != 0)
				fail_count <= fail_count + errs;
		end
	end

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps

module tb;

	localparam logic [1:0] OP_UNUSED = 2'd3;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  opcode;
	logic        side;
	logic [7:0]  price_tick;
	logic [31:0] quantity;
	logic [9:0]  order_id;
	logic        strobe;
	logic [2:0]  status;
	logic [9:0]  resting_id;
	logic [31:0] exec_qty;
	logic [7:0]  fill_price;
	logic [31:0] unfilled_qty;
	logic        last;
	int          fail_count;
	int          pending;

	// ids handed out to adds; lets cancels and dup adds hit live orders
	logic [9:0] used_ids[1024];
	int         n_used = 0;

	limit_order_book_matcher dut (.*);

	lobm_checker chk (.*);

	initial clk = 0;
	always #5 clk = ~clk;

	// Send one word: hold start until the block takes it, then drop start
	// unless the caller's next word follows with no gap.
	task automatic send_word(logic [1:0] op, logic sd, logic [7:0] px,
		logic [31:0] qty, logic [9:0] id);
		int gap;
		opcode <= op; side <= sd; price_tick <= px;
		quantity <= qty; order_id <= id; start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		if (op == lobm_pkg::OP_ADD && n_used < 1024) begin
			used_ids[n_used] = id;
			n_used++;
		end
		// gaps: mostly none or short, a few long
		gap = $urandom_range(0, 9);
		if (gap >= 7) gap = $urandom_range(1, 3);
		else if (gap == 6) gap = $urandom_range(10, 40);
		else gap = 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic logic [9:0] pick_id();
		if (n_used > 0 && $urandom_range(0, 3) != 0)
			return used_ids[$urandom_range(0, n_used - 1)];
		return 10'($urandom_range(0, 1023));
	endfunction

	function automatic logic [31:0] pick_qty();
		case ($urandom_range(0, 7))
			0: return 32'd0;
			1: return $urandom();
			2: return 32'hFFFF_FFFF;
			default: return $urandom_range(1, 20);
		endcase
	endfunction

	initial begin
		int wait_cycles;
		int op_pick;
		arst_n = 1'b0;
		start = 1'b0;
		opcode = lobm_pkg::OP_ADD;
		side = 1'b0;
		price_tick = 8'd0;
		quantity = 32'd0;
		order_id = 10'd0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty book, extremes, zero sizes, dups, partials
		send_word(lobm_pkg::OP_MARKET, 1'b0, 8'd0, 32'd5, 10'd0);       // no liquidity
		send_word(lobm_pkg::OP_MARKET, 1'b1, 8'd0, 32'd0, 10'd0);       // zero-size market
		send_word(lobm_pkg::OP_CANCEL, 1'b0, 8'd0, 32'd0, 10'd1023);    // unknown cancel
		send_word(lobm_pkg::OP_ADD, 1'b1, 8'd255, 32'hFFFF_FFFF, 10'd1023);
		send_word(lobm_pkg::OP_ADD, 1'b1, 8'd0, 32'd10, 10'd0);
		send_word(lobm_pkg::OP_ADD, 1'b1, 8'd0, 32'd0, 10'd1);          // zero-size rests
		send_word(lobm_pkg::OP_ADD, 1'b1, 8'd0, 32'd7, 10'd2);
		send_word(lobm_pkg::OP_ADD, 1'b1, 8'd0, 32'd3, 10'd0);          // duplicate id
		send_word(lobm_pkg::OP_ADD, 1'b0, 8'd255, 32'd4, 10'd3);
		send_word(lobm_pkg::OP_ADD, 1'b0, 8'd0, 32'd9, 10'd4);
		send_word(lobm_pkg::OP_MARKET, 1'b0, 8'd0, 32'd4, 10'd0);       // partial fill of 0
		send_word(lobm_pkg::OP_MARKET, 1'b0, 8'd0, 32'd8, 10'd0);       // 6, zero fill, 2
		send_word(lobm_pkg::OP_CANCEL, 1'b1, 8'd0, 32'd0, 10'd2);       // cancel partial rest
		send_word(OP_UNUSED, 1'b1, 8'd9, 32'd9, 10'd9);                 // unused opcode
		send_word(lobm_pkg::OP_MARKET, 1'b1, 8'd0, 32'hFFFF_FFFF, 10'd0); // sweep buys
		for (int i = 0; i < 70; i++)                         // more than the fill cap
			send_word(lobm_pkg::OP_ADD, 1'b1, 8'($urandom_range(0, 255)), 32'd1,
				10'(100 + i));
		send_word(lobm_pkg::OP_MARKET, 1'b0, 8'd0, 32'd100, 10'd0);
		send_word(lobm_pkg::OP_MARKET, 1'b0, 8'd0, 32'hFFFF_FFFF, 10'd0);

		// random: mostly adds on a few ticks plus sweeps and cancels
		for (int n = 0; n < 230; n++) begin
			op_pick = $urandom_range(0, 19);
			if (op_pick < 10)
				send_word(lobm_pkg::OP_ADD, 1'($urandom()),
					($urandom_range(0, 3) == 0) ? 8'($urandom()) : 8'($urandom_range(100, 107)),
					pick_qty(), pick_id());
			else if (op_pick < 14)
				send_word(lobm_pkg::OP_CANCEL, 1'($urandom()), 8'($urandom()), $urandom(),
					pick_id());
			else if (op_pick < 19)
				send_word(lobm_pkg::OP_MARKET, 1'($urandom()), 8'($urandom()), pick_qty(),
					10'($urandom()));
			else
				send_word(OP_UNUSED, 1'($urandom()), 8'($urandom()), $urandom(),
					10'($urandom()));
		end
		start <= 1'b0;

		// wait out the last item and its words
		wait_cycles = 0;
		@(posedge clk);
		while ((pending != 0 || busy) && wait_cycles < 100000) begin
			@(posedge clk);
			wait_cycles++;
		end
		// let the final compare land
		repeat (2) @(posedge clk);
		if (pending == 0 && fail_count == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

	initial begin
		#20ms;
		$display("tb NOT OK");
		$finish;
	end

endmodule
